/* rtl/qpht_pkg.sv */
// Shared types and constants of the quadratic probing hash table.
package qpht_pkg;

  // fixed field widths
  localparam int KEY_W      = 20;
  localparam int SIZE_W     = 11;
  localparam int STATUS_W   = 2;
  localparam int PROBES_W   = 11;
  localparam int SLOT_W     = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - PROBES_W - SLOT_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [SIZE_W-1:0]   cfg_t;
  typedef logic [PROBES_W-1:0] probes_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_adv;     // zero one entry and advance the clear address
    logic    load;        // capture the input word
    logic    mod_step;    // one bit of the key reduction
    logic    probe_init;  // start the probe walk at key mod size
    logic    probe_adv;   // move to the next probe slot
    logic    write_key;   // store the key at the current slot
    logic    out_load;    // load the result register
    logic    out_use_idx; // result carries the current slot
    logic    out_use_cnt; // result carries the probe count
    status_e out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic key_zero;
    logic act_lookup;
    logic rd_empty;
    logic rd_match;
    logic last_ins;   // this probe is the last one an insert may make
    logic last_lkp;   // this probe is the last one a lookup may make
    logic out_free;
  } sts_t;

endpackage

/* rtl/qpht_dp.sv */
// Datapath: size register, key reduction, probe walk, slot memory and result register.
module qpht_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  qpht_pkg::cfg_t                    cfg_wdata_i,
  input  qpht_pkg::key_t                    key_i,
  input  logic                              act_i,
  input  logic                              m_ready_i,
  output logic                              m_valid_o,
  output logic [qpht_pkg::OUT_DATA_W-1:0]   m_data_o,
  input  qpht_pkg::cmd_t                    cmd_i,
  output qpht_pkg::sts_t                    sts_o
);

  localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SizeW = $clog2(TABLE_DEPTH + 1);
  localparam int ExtW  = SizeW + 1;
  localparam int CntW  = $clog2(TABLE_DEPTH + 2);
  localparam int ModW  = $clog2(qpht_pkg::KEY_W);

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [ExtW-1:0]  ext_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ModW-1:0]  mod_t;

  qpht_pkg::cfg_t cfg_q;
  size_t          s_eff;
  logic           s_is_one;

  qpht_pkg::key_t key_q;
  logic           act_q;
  size_t          rem_q, rem_d;
  ext_t           rem_ext;
  mod_t           mod_cnt_q;
  idx_t           idx_q;
  idx_t           step_q;
  cnt_t           cnt_q, cnt_nx;
  ext_t           idx_sum, idx_nx, step_sum, step_nx;

  qpht_pkg::key_t mem_q [TABLE_DEPTH];
  qpht_pkg::key_t rd_q;
  logic           mem_we;
  qpht_pkg::key_t mem_wdata;

  logic                            out_vld_q;
  logic [qpht_pkg::OUT_DATA_W-1:0] out_q;
  qpht_pkg::slot_t                 res_slot;
  qpht_pkg::probes_t               res_probes;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= qpht_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // clamp the size into 1 .. depth
  always_comb begin
    if (cfg_q == '0) begin
      s_eff = size_t'(1);
    end else if (32'(cfg_q) > TABLE_DEPTH) begin
      s_eff = size_t'(TABLE_DEPTH);
    end else begin
      s_eff = size_t'(cfg_q);
    end
  end
  assign s_is_one = (s_eff == size_t'(1));

  // one restoring step of key mod size, most significant bit first
  always_comb begin
    rem_ext = {rem_q, key_q[mod_cnt_q]};
    if (rem_ext >= ext_t'(s_eff)) begin
      rem_d = size_t'(rem_ext - ext_t'(s_eff));
    end else begin
      rem_d = size_t'(rem_ext);
    end
  end

  // next slot: add the step, then advance the step by two, both mod size
  always_comb begin
    idx_sum  = ext_t'(idx_q) + ext_t'(step_q);
    idx_nx   = (idx_sum >= ext_t'(s_eff)) ? idx_sum - ext_t'(s_eff) : idx_sum;
    step_sum = ext_t'(step_q) + ext_t'(2);
    if (s_is_one) begin
      step_nx = '0;
    end else if (step_sum >= ext_t'(s_eff)) begin
      step_nx = step_sum - ext_t'(s_eff);
    end else begin
      step_nx = step_sum;
    end
  end
  assign cnt_nx = cnt_q + cnt_t'(1);

  // slot address doubles as the clear address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clr_adv) begin
      idx_q <= idx_q + idx_t'(1);
    end else if (cmd_i.probe_init) begin
      idx_q <= idx_t'(rem_d);
    end else if (cmd_i.probe_adv) begin
      idx_q <= idx_t'(idx_nx);
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q     <= key_i;
      act_q     <= act_i;
      rem_q     <= '0;
      mod_cnt_q <= mod_t'(qpht_pkg::KEY_W - 1);
    end else if (cmd_i.mod_step) begin
      rem_q     <= rem_d;
      mod_cnt_q <= mod_cnt_q - mod_t'(1);
    end
    if (cmd_i.probe_init) begin
      step_q <= s_is_one ? idx_t'(0) : idx_t'(1);
      cnt_q  <= '0;
    end else if (cmd_i.probe_adv) begin
      step_q <= idx_t'(step_nx);
      cnt_q  <= cnt_nx;
    end
  end

  // slot memory, one write and one registered read a cycle
  assign mem_we    = cmd_i.clr_adv | cmd_i.write_key;
  assign mem_wdata = cmd_i.write_key ? key_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  // result register
  assign res_slot   = cmd_i.out_use_idx ? qpht_pkg::slot_t'(idx_q) : '0;
  assign res_probes = cmd_i.out_use_cnt ? qpht_pkg::probes_t'(cnt_nx) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {{qpht_pkg::OUT_PAD_W{1'b0}}, res_slot, res_probes, cmd_i.out_status};
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_q;

  // status to the controller
  assign sts_o.clr_last   = (idx_q == idx_t'(TABLE_DEPTH - 1));
  assign sts_o.mod_last   = (mod_cnt_q == '0);
  assign sts_o.key_zero   = (key_q == '0);
  assign sts_o.act_lookup = (act_q == qpht_pkg::ACT_LOOKUP);
  assign sts_o.rd_empty   = (rd_q == '0);
  assign sts_o.rd_match   = (rd_q == key_q);
  assign sts_o.last_ins   = (cnt_nx == cnt_t'(s_eff));
  assign sts_o.last_lkp   = (cnt_nx == cnt_t'(s_eff) + cnt_t'(1));
  assign sts_o.out_free   = !out_vld_q || m_ready_i;

  // a key only lands on a slot that read back empty
  a_write_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_key |-> (rd_q == '0))
    else $error("key written over an occupied slot");

  // the walk stays inside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe_adv |=> (ext_t'(idx_q) < ext_t'(s_eff)))
    else $error("probe slot beyond table size");

  // the walk only moves on past an occupied slot
  a_adv_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe_adv |-> (rd_q != '0))
    else $error("probe advanced past an empty slot");

  // a result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_vld_q || m_ready_i))
    else $error("result register overwritten");

endmodule

/* rtl/qpht_ctrl.sv */
// Controller: clear pass, key reduction and probe walk sequencing.
module qpht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  qpht_pkg::sts_t sts_i,
  output qpht_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_adv = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.key_zero) begin
          // zero key: answer without a probe once the result register is free
          if (sts_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = sts_i.act_lookup ? qpht_pkg::ST_MISSING : qpht_pkg::ST_FULL;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.mod_step = 1'b1;
          if (sts_i.mod_last) begin
            cmd_o.probe_init = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.act_lookup) begin
          priority if (sts_i.rd_empty) begin
            if (sts_i.out_free) begin
              cmd_o.write_key   = 1'b1;
              cmd_o.out_load    = 1'b1;
              cmd_o.out_use_idx = 1'b1;
              cmd_o.out_status  = qpht_pkg::ST_INSERTED;
              state_d           = S_IDLE;
            end
          end else if (sts_i.last_ins) begin
            if (sts_i.out_free) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = qpht_pkg::ST_FULL;
              state_d          = S_IDLE;
            end
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d         = S_READ;
          end
        end else begin
          priority if (sts_i.rd_match) begin
            if (sts_i.out_free) begin
              cmd_o.out_load    = 1'b1;
              cmd_o.out_use_idx = 1'b1;
              cmd_o.out_use_cnt = 1'b1;
              cmd_o.out_status  = qpht_pkg::ST_FOUND;
              state_d           = S_IDLE;
            end
          end else if (sts_i.rd_empty || sts_i.last_lkp) begin
            if (sts_i.out_free) begin
              cmd_o.out_load    = 1'b1;
              cmd_o.out_use_cnt = 1'b1;
              cmd_o.out_status  = qpht_pkg::ST_MISSING;
              state_d           = S_IDLE;
            end
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

  // a stored key always comes with its result
  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_key |-> (cmd_o.out_load && cmd_o.out_status == qpht_pkg::ST_INSERTED))
    else $error("key stored without an insert result");

endmodule

/* rtl/quadratic_probe_hash_table_unit.sv */
// Top level of the quadratic probing hash table.
//
// Input channel s_axis: one word per request; tuser selects insert (0) or lookup (1),
// tdata carries the key. Output channel m_axis: one word per request with status,
// probe count and slot. The user writes the table size register through cfg_we_i /
// cfg_wdata_i only while no request is in flight; the block does not enforce this.
//
// After reset the slot memory is swept to empty, one entry a cycle, while
// s_axis_tready stays low. The size resets to 1021.
//
// A request with a nonzero key first reduces the key modulo the table size
// (one key bit per cycle), then walks its probes, each a memory read (S_READ)
// and then a compare (S_CHECK). The result is loaded in the compare of the
// last probe, and the next word can be taken in the cycle after that. A zero
// key is answered from S_MOD, without a probe, once the output register is free.
// A result waiting in the output register does not block the next input
// word; if the receiver still stalls when the next result is ready, the
// block holds that request in its last step without writing anything.
module quadratic_probe_hash_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // table size register
  input  logic                            cfg_we_i,
  input  qpht_pkg::cfg_t                  cfg_wdata_i,
  // requests
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [qpht_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [19:0] key
  input  logic                            s_axis_tuser,  // [0] action
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [qpht_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [1:0] status, [12:2] probes,
                                                         // [22:13] slot
);

  qpht_pkg::cmd_t cmd;
  qpht_pkg::sts_t sts;

  qpht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  qpht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_i       (s_axis_tdata[qpht_pkg::KEY_W-1:0]),
    .act_i       (s_axis_tuser),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
